// ----- hdl/rcpg_pkg.sv -----
// Shared types, constants and the color wheel function for the rainbow cycle
// pixel generator. No dependencies.
`timescale 1ns / 1ps

package rcpg_pkg;

  localparam int MAX_PIXELS_DEF = 64;
  localparam int INSTANCES_DEF  = 10;

  localparam int INST_W     = 4;
  localparam int PIX_W      = 6;
  localparam int CH_W       = 8;
  localparam int RANGE_W    = 7;
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [POS_W-1:0] WHEEL_TOP = 11'd1280;

  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR    = 3'd4;

  // serial divider geometry
  localparam int DVD_W   = 16;
  localparam int DVS_W   = 8;
  localparam int RECIP_W = DVD_W + 1;
  localparam int PROD_W  = CH_W + RECIP_W;

  localparam logic [1:0] OP_STEP  = 2'd0;  // 256 / span
  localparam logic [1:0] OP_BASE  = 2'd1;  // start * 256 / span
  localparam logic [1:0] OP_RECIP = 2'd2;  // 65535 / divisor

  localparam logic [CH_W-1:0] HUE_SEG1 = 8'd85;
  localparam logic [CH_W-1:0] HUE_SEG2 = 8'd170;
  localparam logic [CH_W-1:0] CH_MAX   = 8'd255;
  localparam logic [9:0]      HUE_GAIN = 10'd3;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic [1:0] div_op;
    logic       div_cap;
    logic       hue;
    logic       mul;
    logic       next;
    logic       upd;
  } rcpg_cmd_t;

  typedef struct packed {
    logic inst_ok;
    logic range_ok;
    logic div_done;
    logic last;
  } rcpg_sts_t;

  function automatic rgb_t hue_to_rgb(input logic [CH_W-1:0] h);
    logic [CH_W-1:0] hh;
    logic [9:0]      h3;
    rgb_t            c;
    if (h < HUE_SEG1) begin
      hh = h;
    end else if (h < HUE_SEG2) begin
      hh = h - HUE_SEG1;
    end else begin
      hh = h - HUE_SEG2;
    end
    h3 = 10'(hh) * HUE_GAIN;
    if (h < HUE_SEG1) begin
      c.r = h3[CH_W-1:0];
      c.g = CH_MAX - h3[CH_W-1:0];
      c.b = '0;
    end else if (h < HUE_SEG2) begin
      c.r = CH_MAX - h3[CH_W-1:0];
      c.g = '0;
      c.b = h3[CH_W-1:0];
    end else begin
      c.r = '0;
      c.g = h3[CH_W-1:0];
      c.b = CH_MAX - h3[CH_W-1:0];
    end
    return c;
  endfunction

endpackage

// ----- hdl/rcpg_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Depends on rcpg_pkg.
`timescale 1ns / 1ps

module rcpg_div
  import rcpg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  always_comb begin
    trial    = {rem_r, q_r[DVD_W-1]};
    diff     = trial - {1'b0, dsr_r};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DVS_W]) begin
        rem_nxt = diff[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

// ----- hdl/rcpg_dp.sv -----
// Datapath: config registers, wheel positions, hue stepping, color decode
// and reciprocal scaling. Depends on rcpg_pkg and rcpg_div.
`timescale 1ns / 1ps

module rcpg_dp
  import rcpg_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int INSTANCES  = INSTANCES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [INST_W-1:0]     instance_req,
  input  rcpg_cmd_t             cmd,
  output rcpg_sts_t             sts,
  output logic [PIX_W-1:0]      pixel_index,
  output logic [CH_W-1:0]       red,
  output logic [CH_W-1:0]       green,
  output logic [CH_W-1:0]       blue
);

  localparam int IW = (INSTANCES > 1) ? $clog2(INSTANCES) : 1;
  localparam logic [RANGE_W-1:0] MAX_END = RANGE_W'(MAX_PIXELS);

  logic [RANGE_W-1:0] start_r, end_r;
  logic [CH_W-1:0]    bright_r, speed_r;
  logic               dir_r;
  logic [POS_W-1:0]   pos_r [INSTANCES];
  logic [INST_W-1:0]  inst_r;
  logic [RANGE_W-1:0] pix_r;
  logic [CH_W-1:0]    q_r, step_q_r;
  logic [RANGE_W-1:0] rem_r, step_rem_r;
  logic [RECIP_W-1:0] recip_r;
  rgb_t               rgb_r;
  logic [CH_W-1:0]    red_r, green_r, blue_r;

  logic [RANGE_W-1:0] end_eff, span;
  logic [CH_W-1:0]    div_eff;
  logic [IW-1:0]      idx;
  logic [POS_W-1:0]   pos_cur, pos_nxt;
  logic [POS_W:0]     pos_sum;
  logic [CH_W-1:0]    hue;
  logic [RANGE_W:0]   rem_sum;
  logic [PROD_W-1:0]  prod_r, prod_g, prod_b;
  logic [DVD_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               div_done;
  logic [DVD_W-1:0]   div_q;
  logic [DVS_W-1:0]   div_rem;

  always_comb begin
    end_eff = (end_r > MAX_END) ? MAX_END : end_r;
    span    = end_eff - start_r;
    div_eff = (bright_r == '0) ? CH_W'(1) : bright_r;
    idx     = inst_r[IW-1:0];
    pos_cur = pos_r[idx];
    hue     = q_r + pos_cur[CH_W-1:0];
    rem_sum = {1'b0, rem_r} + {1'b0, step_rem_r};
    pos_sum = {1'b0, pos_cur} + (POS_W+1)'(speed_r);
    if (dir_r) begin
      pos_nxt = (pos_sum > {1'b0, WHEEL_TOP}) ? '0 : pos_sum[POS_W-1:0];
    end else begin
      pos_nxt = (POS_W'(speed_r) > pos_cur) ? WHEEL_TOP : pos_cur - POS_W'(speed_r);
    end
    prod_r = PROD_W'(rgb_r.r) * PROD_W'(recip_r);
    prod_g = PROD_W'(rgb_r.g) * PROD_W'(recip_r);
    prod_b = PROD_W'(rgb_r.b) * PROD_W'(recip_r);
  end

  always_comb begin
    case (cmd.div_op)
      OP_STEP: begin
        dvd = DVD_W'(256);
        dvs = DVS_W'(span);
      end
      OP_BASE: begin
        dvd = DVD_W'({start_r, 8'd0});
        dvs = DVS_W'(span);
      end
      default: begin
        dvd = '1;
        dvs = div_eff;
      end
    endcase
  end

  rcpg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      end_r    <= RANGE_W'(64);
      bright_r <= CH_W'(1);
      speed_r  <= CH_W'(1);
      dir_r    <= 1'b1;
      for (int k = 0; k < INSTANCES; k++) begin
        pos_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START:  start_r  <= cfg_data[RANGE_W-1:0];
          REG_END:    end_r    <= cfg_data[RANGE_W-1:0];
          REG_BRIGHT: bright_r <= cfg_data;
          REG_SPEED:  speed_r  <= cfg_data;
          REG_DIR:    dir_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.upd) begin
        pos_r[idx] <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inst_r <= instance_req;
      pix_r  <= start_r;
    end
    if (cmd.div_cap) begin
      case (cmd.div_op)
        OP_STEP: begin
          step_q_r   <= div_q[CH_W-1:0];
          step_rem_r <= div_rem[RANGE_W-1:0];
        end
        OP_BASE: begin
          q_r   <= div_q[CH_W-1:0];
          rem_r <= div_rem[RANGE_W-1:0];
        end
        default: recip_r <= {1'b0, div_q} + RECIP_W'(1);
      endcase
    end
    if (cmd.hue) begin
      rgb_r <= hue_to_rgb(hue);
    end
    if (cmd.mul) begin
      red_r   <= prod_r[DVD_W+CH_W-1:DVD_W];
      green_r <= prod_g[DVD_W+CH_W-1:DVD_W];
      blue_r  <= prod_b[DVD_W+CH_W-1:DVD_W];
    end
    if (cmd.next) begin
      pix_r <= pix_r + 1'b1;
      if (rem_sum >= {1'b0, span}) begin
        rem_r <= RANGE_W'(rem_sum - {1'b0, span});
        q_r   <= q_r + step_q_r + 1'b1;
      end else begin
        rem_r <= rem_sum[RANGE_W-1:0];
        q_r   <= q_r + step_q_r;
      end
    end
  end

  assign sts.inst_ok  = ({1'b0, inst_r} < (INST_W+1)'(INSTANCES));
  assign sts.range_ok = (end_eff > start_r);
  assign sts.div_done = div_done;
  assign sts.last     = ((pix_r + 1'b1) == end_eff);

  assign pixel_index = pix_r[PIX_W-1:0];
  assign red         = red_r;
  assign green       = green_r;
  assign blue        = blue_r;

endmodule

// ----- hdl/rcpg_ctrl.sv -----
// Frame sequencer: setup divisions, per-pixel decode/scale/output, position
// update. Depends on rcpg_pkg.
`timescale 1ns / 1ps

module rcpg_ctrl
  import rcpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  rcpg_sts_t sts,
  output rcpg_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_HUE      = 3'd4;
  localparam logic [2:0] S_MUL      = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;
  localparam logic [2:0] S_UPD      = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] op_r, op_nxt;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cmd        = '0;
    cmd.div_op = op_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.inst_ok) begin
          state_nxt = S_IDLE;
        end else if (!sts.range_ok) begin
          state_nxt = S_UPD;
        end else begin
          op_nxt    = OP_STEP;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_cap = 1'b1;
          case (op_r)
            OP_STEP: begin
              op_nxt    = OP_BASE;
              state_nxt = S_DIV_GO;
            end
            OP_BASE: begin
              op_nxt    = OP_RECIP;
              state_nxt = S_DIV_GO;
            end
            default: state_nxt = S_HUE;
          endcase
        end
      end
      S_HUE: begin
        cmd.hue   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.last) begin
            state_nxt = S_UPD;
          end else begin
            cmd.next  = 1'b1;
            state_nxt = S_HUE;
          end
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_STEP;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  a_bad_inst_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !sts.inst_ok) |=> (state_r == S_IDLE))
    else $error("out-of-range instance did not return to idle");

  a_last_updates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && sts.last) |=> (state_r == S_UPD))
    else $error("last beat not followed by position update");

  a_recip_to_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_WAIT && sts.div_done && op_r == OP_RECIP) |=> (state_r == S_HUE))
    else $error("pixel loop did not start after setup divisions");

  a_next_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.next |-> !sts.last)
    else $error("pixel counter advanced past frame end");

endmodule

// ----- hdl/rainbow_cycle_pixel_generator_core.sv -----
// Top level of the rainbow cycle pixel generator: stream ports, config port.
// Depends on rcpg_pkg, rcpg_ctrl, rcpg_dp.
`timescale 1ns / 1ps

// Each input beat is a frame tick for one animation instance; the block then
// sends one output beat per pixel from start_pixel up to, but not including,
// the clamped end, with tlast on the final pixel, and afterwards steps that
// instance's wheel position. A frame runs through these steps in order: accept
// the tick, check the instance and range, three 16-step serial divisions (hue
// step, base hue, reciprocal of the brightness divisor), then for each pixel a
// color decode, the reciprocal multiply and the output beat, which waits for
// out_tready, and last the write of the wheel position. An out-of-range
// instance emits nothing; an empty pixel range only moves the wheel. One frame
// is processed at a time; the next tick is taken once that frame is finished.
module rainbow_cycle_pixel_generator_core
  import rcpg_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF,
  parameter int INSTANCES  = INSTANCES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [3:0] instance_req
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [5:0] pixel_index, [13:6] red,
                                            // [21:14] green, [29:22] blue
  output logic                  out_tlast,  // last_pixel
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rcpg_cmd_t        cmd;
  rcpg_sts_t        sts;
  logic [PIX_W-1:0] pixel_index;
  logic [CH_W-1:0]  red, green, blue;

  rcpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rcpg_dp #(
    .MAX_PIXELS (MAX_PIXELS),
    .INSTANCES  (INSTANCES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .instance_req (in_tdata[INST_W-1:0]),
    .cmd          (cmd),
    .sts          (sts),
    .pixel_index  (pixel_index),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

  assign out_tdata = {2'b00, blue, green, red, pixel_index};
  assign out_tlast = sts.last;

endmodule
